### rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the paged bump allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int PBA_MAX_PAGES_DEF = 64;

    localparam int SIZE_W   = 24;
    localparam int ALIGN_W  = 5;
    localparam int PSIZE_W  = 25;
    localparam int PAGE_W   = 6;
    localparam int STATUS_W = 2;
    // Wide enough for a 24-bit value aligned up to 2^31.
    localparam int CALC_W   = 33;

    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 25'd2097152;
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_CAP = 25'd16777216;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_PAGES = 2'd2;

    typedef struct packed {
        logic               func;
        logic [SIZE_W-1:0]  request_size;
        logic [ALIGN_W-1:0] align_log2;
    } pba_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_index;
        logic [SIZE_W-1:0]   byte_offset;
        logic                new_page;
    } pba_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the request
        logic calc;    // align offset and size
        logic commit;  // choose page, update state, load result
    } pba_cmd_t;

endpackage

### rtl/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer: capture, align, commit, then hold the result until taken.
// ----------------------------------------------------------------------------
module pba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pba_pkg::pba_cmd_t cmd
);
    import pba_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CALC   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_OUT    = 4'b1000
    } pba_state_t;

    pba_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign cmd.load   = in_ready && in_valid;
    assign cmd.calc   = (state_reg == ST_CALC);
    assign cmd.commit = (state_reg == ST_DECIDE);

    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.calc)
        else $error("accepted request did not start alignment");

    a_commit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit not followed by a valid result");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && !in_ready))
        else $error("stalled result dropped or new request taken");

endmodule

### rtl/pba_datapath.sv
// ----------------------------------------------------------------------------
// pba_datapath
// Page size register, allocator state, alignment math and result register.
// ----------------------------------------------------------------------------
module pba_datapath #(
    parameter int MAX_PAGES = pba_pkg::PBA_MAX_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pba_pkg::PSIZE_W-1:0]    cfg_data,
    input  pba_pkg::pba_req_t              in_req,
    input  pba_pkg::pba_cmd_t              cmd,
    output pba_pkg::pba_rsp_t              out_rsp
);
    import pba_pkg::*;

    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int PW = (CW > PAGE_W) ? CW : PAGE_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAGES);

    logic [PSIZE_W-1:0] page_size_reg;
    pba_req_t           req_reg;
    logic [PSIZE_W-1:0] psz_reg;
    logic [CALC_W-1:0]  asz_reg;
    logic [CALC_W-1:0]  off_reg;
    logic               too_big_reg;
    logic [PSIZE_W-1:0] fill_offset_reg, fill_offset_next;
    logic [PAGE_W-1:0]  active_page_reg, active_page_next;
    logic [CW-1:0]      pages_made_reg, pages_made_next;
    logic [CW-1:0]      free_count_reg, free_count_next;
    pba_rsp_t           rsp_reg, rsp_next;

    // Alignment stage
    logic [CALC_W-1:0]  mask;
    logic [CALC_W-1:0]  asz_calc;
    logic [CALC_W-1:0]  off_calc;
    logic [PSIZE_W-1:0] psz_calc;

    always_comb
    begin
        mask     = (CALC_W'(1) << req_reg.align_log2) - CALC_W'(1);
        asz_calc = (CALC_W'(req_reg.request_size) + mask) & ~mask;
        off_calc = (CALC_W'(fill_offset_reg) + mask) & ~mask;
        psz_calc = (page_size_reg > PAGE_SIZE_CAP) ? PAGE_SIZE_CAP : page_size_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
        end
        if (cmd.calc)
        begin
            asz_reg     <= asz_calc;
            off_reg     <= off_calc;
            psz_reg     <= psz_calc;
            too_big_reg <= (CALC_W'(req_reg.request_size) >= CALC_W'(psz_calc))
                        || (asz_calc > CALC_W'(psz_calc));
        end
    end

    // Commit stage
    logic [CALC_W:0]   end_sum;
    logic              fits;
    logic              need_page;
    logic [PW-1:0]     page_sel;

    always_comb
    begin
        end_sum   = {1'b0, off_reg} + {1'b0, asz_reg};
        fits      = (off_reg < CALC_W'(psz_reg)) && (end_sum <= (CALC_W + 1)'(psz_reg));
        need_page = (pages_made_reg == '0) || !fits;
        page_sel  = PW'(active_page_reg);

        fill_offset_next = fill_offset_reg;
        active_page_next = active_page_reg;
        pages_made_next  = pages_made_reg;
        free_count_next  = free_count_reg;
        rsp_next         = '0;
        rsp_next.status  = STAT_OK;

        if (req_reg.func == FUNC_RESET)
        begin
            fill_offset_next = '0;
            active_page_next = '0;
            free_count_next  = (pages_made_reg != '0) ? pages_made_reg - CW'(1) : '0;
        end
        else if (too_big_reg)
        begin
            rsp_next.status = STAT_TOO_BIG;
        end
        else if (need_page && free_count_reg == '0 && pages_made_reg >= MAX_CNT)
        begin
            rsp_next.status = STAT_NO_PAGES;
        end
        else
        begin
            if (need_page)
            begin
                if (free_count_reg != '0)
                begin
                    page_sel        = PW'(free_count_reg);
                    free_count_next = free_count_reg - CW'(1);
                end
                else
                begin
                    page_sel          = PW'(pages_made_reg);
                    pages_made_next   = pages_made_reg + CW'(1);
                    rsp_next.new_page = 1'b1;
                end
                // new page: start at offset zero
                fill_offset_next = PSIZE_W'(asz_reg);
                rsp_next.byte_offset = '0;
            end
            else
            begin
                fill_offset_next     = PSIZE_W'(end_sum);
                rsp_next.byte_offset = off_reg[SIZE_W-1:0];
            end
            active_page_next    = page_sel[PAGE_W-1:0];
            rsp_next.page_index = page_sel[PAGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= PAGE_SIZE_RST;
            fill_offset_reg <= '0;
            active_page_reg <= '0;
            pages_made_reg  <= '0;
            free_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                page_size_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                fill_offset_reg <= fill_offset_next;
                active_page_reg <= active_page_next;
                pages_made_reg  <= pages_made_next;
                free_count_reg  <= free_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_rsp = rsp_reg;

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_made_reg <= MAX_CNT)
        else $error("page count beyond limit");

    a_free_below_made: assert property (@(posedge clk) disable iff (!rst_n)
        (free_count_reg == '0) || (free_count_reg < pages_made_reg))
        else $error("free set reaches past created pages");

    a_new_page_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && rsp_next.new_page)
            |=> (pages_made_reg == $past(pages_made_reg) + CW'(1)))
        else $error("fresh page reported without count update");

endmodule

### rtl/paged_bump_allocator.sv
// ----------------------------------------------------------------------------
// paged_bump_allocator
// Linear bump allocator over fixed-size pages with page recycling.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with in_req (func, request_size,
//   align_log2); results leave on out_valid/out_ready with out_rsp (status,
//   page_index, byte_offset, new_page). Every request, allocate or reset,
//   yields exactly one result.
//   cfg_we/cfg_data write the page size; write it only while the block idles.
//   After a request is accepted it passes the align state, then the commit
//   state that loads the result register, before out_valid rises. in_ready
//   returns the cycle after the result is taken; the controller runs a
//   single request at a time.
//   A stalled receiver holds the result steady and keeps in_ready low.
//   After rst_n: page size 2097152, no pages created, free set empty, offset
//   zero. A reset request rewinds to page 0 and frees pages 1..made-1, which
//   are then reused highest index first before fresh pages are made.
//   Status: too big when the size reaches a page or its aligned form
//   exceeds it; out of pages when a new page is needed, MAX_PAGES in use.
// ----------------------------------------------------------------------------
module paged_bump_allocator #(
    parameter int MAX_PAGES = pba_pkg::PBA_MAX_PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pba_pkg::PSIZE_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pba_pkg::pba_req_t           in_req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pba_pkg::pba_rsp_t           out_rsp
);
    import pba_pkg::*;

    pba_cmd_t cmd;

    // Sequencer: one request in flight
    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Page state, alignment math, result register
    pba_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_req   (in_req),
        .cmd      (cmd),
        .out_rsp  (out_rsp)
    );

endmodule

### verif/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the paged bump allocator. A queue-fed driver
// offers requests with random gaps and a monitor takes results with random
// stalls. Each accepted request runs through a local copy of the allocator
// state to give the expected grant. Phases switch the page size while the
// block is idle, from zero through the cap and beyond.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int MAX_PAGES  = PBA_MAX_PAGES_DEF;
    localparam int STUCK_MAX  = 2000;   // cycles with no handshake on either side
    localparam int N_PHASES   = 10;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic [PSIZE_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    pba_req_t            in_req   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    pba_rsp_t            out_rsp;

    // Requests waiting for the driver, grants waiting for the monitor
    pba_req_t pending_reqs[$];
    pba_rsp_t grants_due[$];
    int       n_queued   = 0;
    int       n_taken    = 0;
    int       mismatches = 0;
    int       stuck_cyc  = 0;
    int       gap_left   = 0;
    int       stall_left = 0;
    bit       calm       = 1'b0;   // phase without gaps or stalls

    // Local copy of the allocator state, same reset as the block
    bit [PSIZE_W-1:0] page_bytes = PAGE_SIZE_RST;
    bit [63:0]        fill_pos   = '0;
    int unsigned      cur_page   = 0;
    int unsigned      made_cnt   = 0;
    int unsigned      free_top   = 0;   // free pages are 1..free_top

    paged_bump_allocator #(.MAX_PAGES(MAX_PAGES)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Grant computation: updates the local state and returns what the block
    // must answer for this request.
    // ------------------------------------------------------------------------
    function automatic pba_rsp_t compute_grant(pba_req_t r);
        pba_rsp_t    g;
        bit [63:0]   lim;
        bit [63:0]   mask;
        bit [63:0]   asz;
        bit [63:0]   off;
        int unsigned pg;
        bit          fresh;
        g     = '0;
        fresh = 1'b0;
        lim   = (page_bytes > PAGE_SIZE_CAP) ? 64'(PAGE_SIZE_CAP) : 64'(page_bytes);

        // Rewind: page 0 stays active, all later pages go to the free set
        if (r.func == FUNC_RESET)
        begin
            fill_pos = '0;
            cur_page = 0;
            free_top = (made_cnt > 0) ? made_cnt - 1 : 0;
            return g;
        end

        mask = (64'd1 << r.align_log2) - 64'd1;
        asz  = (64'(r.request_size) + mask) & ~mask;
        // Too big covers both the raw size and its aligned form
        if (64'(r.request_size) >= lim || asz > lim)
        begin
            g.status = STAT_TOO_BIG;
            return g;
        end

        pg  = cur_page;
        off = (fill_pos + mask) & ~mask;
        // Aligned offset must sit strictly inside the page, so a zero-size
        // request on a full page still moves on
        if (made_cnt == 0 || !(off < lim && off + asz <= lim))
        begin
            if (free_top > 0)
            begin
                pg = free_top;
                free_top--;
            end
            else if (made_cnt < MAX_PAGES)
            begin
                pg = made_cnt;
                made_cnt++;
                fresh = 1'b1;
            end
            else
            begin
                g.status = STAT_NO_PAGES;
                return g;
            end
            off = '0;
        end

        cur_page     = pg & 32'h3F;
        fill_pos     = off + asz;
        g.status     = STAT_OK;
        g.page_index = pg[PAGE_W-1:0];
        g.byte_offset = off[SIZE_W-1:0];
        g.new_page   = fresh;
        return g;
    endfunction

    // Random gap or stall length: mostly none or short, now and then long
    function automatic int pick_idle();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Random request shaped around the usable page size
    function automatic pba_req_t make_req(int unsigned lim, int unsigned rst_pct);
        pba_req_t    r;
        int unsigned roll;
        longint      near;
        r.func         = FUNC_ALLOC;
        r.request_size = '0;
        r.align_log2   = 5'($urandom_range(0, 4));
        roll = $urandom_range(0, 99);
        if (roll < rst_pct)
        begin
            // Rewind with junk in the unused fields
            r.func         = FUNC_RESET;
            r.request_size = 24'($urandom());
            r.align_log2   = 5'($urandom());
        end
        else if (roll < rst_pct + 45)
            r.request_size = 24'($urandom_range(0, lim / 8));
        else if (roll < rst_pct + 65)
            r.request_size = 24'($urandom_range(lim / 4, lim / 2));
        else if (roll < rst_pct + 75)
        begin
            // Right around the page size: last fit and first too-big
            near = longint'(lim) + longint'($urandom_range(0, 2)) - 1;
            if (near < 0)
                near = 0;
            if (near > 64'hFF_FFFF)
                near = 64'hFF_FFFF;
            r.request_size = 24'(near);
        end
        else if (roll < rst_pct + 87)
        begin
            r.request_size = 24'($urandom_range(0, lim / 16));
            r.align_log2   = 5'($urandom_range(5, 31));
        end
        else
        begin
            r.request_size = 24'($urandom());
            r.align_log2   = 5'($urandom());
        end
        return r;
    endfunction

    function automatic void queue_req(pba_req_t r);
        pending_reqs = {pending_reqs, r};
        n_queued++;
    endfunction

    // Hold off until every request is in and every grant is back
    task automatic drain();
        while (n_taken != n_queued || grants_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_page_size(bit [PSIZE_W-1:0] v);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_data   <= v;
        page_bytes  = v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: on acceptance the grant is computed and queued; the next
    // request goes out after a random gap and holds until taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_req   <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                grants_due = {grants_due, compute_grant(in_req)};
                n_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_req   <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= pick_idle();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares each taken result with the oldest grant due and
    // throttles out_ready.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pba_rsp_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request pending: %p",
                                 $realtime, out_rsp);
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (out_rsp.status !== want.status ||
                        out_rsp.page_index !== want.page_index ||
                        out_rsp.byte_offset !== want.byte_offset ||
                        out_rsp.new_page !== want.new_page)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp st=%0d pg=%0d off=%0d new=%0d",
                                      " got st=%0d pg=%0d off=%0d new=%0d"},
                                     $realtime, want.status, want.page_index,
                                     want.byte_offset, want.new_page,
                                     out_rsp.status, out_rsp.page_index,
                                     out_rsp.byte_offset, out_rsp.new_page);
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left <= pick_idle();
            end
        end
    end

    // Watchdog: too long with nothing moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cyc <= 0;
        else
            stuck_cyc <= stuck_cyc + 1;
        if (stuck_cyc >= STUCK_MAX)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        bit [PSIZE_W-1:0] ps_list [N_PHASES];
        int unsigned      cnt_list[N_PHASES];
        int unsigned      rst_list[N_PHASES];
        bit               calm_list[N_PHASES];
        int unsigned      lim;

        // Page sizes: reset value, tiny pages that run out, zero, the cap, the
        // all-ones register, more small sizes, 4096 and a random one
        ps_list   = '{25'd2097152, 25'd16, 25'd4, 25'd0, PAGE_SIZE_CAP,
                      25'h1FF_FFFF, 25'd1, 25'd17, 25'd4096, 25'd0};
        ps_list[9] = 25'($urandom_range(16, 1 << 20));
        cnt_list  = '{250, 300, 200, 60, 250, 150, 50, 200, 200, 150};
        rst_list  = '{8, 2, 1, 10, 5, 5, 10, 3, 5, 6};
        calm_list = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests at the reset page size of 2 MiB
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd0,       5'd0});   // first page made
        queue_req(pba_req_t'{FUNC_ALLOC, 24'hFF_FFFF, 5'd0});   // way too big
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd2097152, 5'd0});   // equal to page
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd1,       5'd31});  // aligned size too big
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd0,       5'd31});  // zero size, huge align
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd100,     5'd16});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd2097151, 5'd0});   // spills to page 1
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd1,       5'd0});   // fills page exactly
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd0,       5'd0});   // full page moves on
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd10,      5'd5});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd3,       5'd3});
        queue_req(pba_req_t'{FUNC_RESET, 24'hFF_FFFF, 5'd31});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd2097000, 5'd0});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd1000,    5'd4});   // recycled, top first
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd2097100, 5'd0});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd2097100, 5'd0});   // free set empty, fresh
        queue_req(pba_req_t'{FUNC_ALLOC, 24'h80_0000, 5'd0});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'h15_5555, 5'd1});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'h0A_AAAA, 5'd10});
        queue_req(pba_req_t'{FUNC_RESET, 24'd0,       5'd0});
        queue_req(pba_req_t'{FUNC_RESET, 24'h55_5555, 5'd21});  // back-to-back rewind
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd1,       5'd16});
        queue_req(pba_req_t'{FUNC_ALLOC, 24'd1,       5'd16});

        // Random phases; each switch of page size waits for a quiet block
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            write_page_size(ps_list[p]);
            calm = calm_list[p];
            lim  = (ps_list[p] > PAGE_SIZE_CAP) ? PAGE_SIZE_CAP : ps_list[p];
            for (int i = 0; i < cnt_list[p]; i++)
                queue_req(make_req(lim, rst_list[p]));
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
rtl/pba_pkg.sv
rtl/pba_ctrl.sv
rtl/pba_datapath.sv
rtl/paged_bump_allocator.sv
verif/tb_top.sv
